>>> rtl/kfcd_pkg.sv
// ----------------------------------------------------------------------------
// kfcd_pkg
// shared types, constants and helpers for the key-fob frame counter decoder
// ----------------------------------------------------------------------------
package kfcd_pkg;

    localparam int PREAMBLE_W = 48;
    localparam int LENGTH_W   = 11;
    localparam int PAYLOAD_W  = 64;
    localparam int STATUS_W   = 2;
    localparam int SERIAL_W   = 24;
    localparam int BUTTON_W   = 4;
    localparam int COUNT_W    = 16;

    localparam int IN_DATA_W  = 128;  // 123 field bits padded to whole bytes
    localparam int OUT_DATA_W = 112;  // 108 field bits padded to whole bytes

    localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PREAMBLE_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LENGTH_ERR   = 2'd2;

    localparam logic [7:0]          SYNC_BYTE    = 8'hFF;
    localparam logic [LENGTH_W-1:0] ROW_LEN_MIN  = 11'd64;
    localparam logic [LENGTH_W-1:0] ROW_LEN_MAX  = 11'd65;
    localparam logic [8:0]          ROT_OFFSET   = 9'd4;
    localparam logic [7:0]          ROT_RECIP    = 8'd171;  // ~4096/24
    localparam int                  ROT_RECIP_SH = 12;
    localparam logic [4:0]          ROT_MODULUS  = 5'd24;

    typedef struct packed {
        logic [PREAMBLE_W-1:0] preamble_bytes;
        logic [LENGTH_W-1:0]   row_length;
        logic [PAYLOAD_W-1:0]  payload;
    } kfcd_frame_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [SERIAL_W-1:0]  serial_number;
        logic [BUTTON_W-1:0]  button;
        logic [COUNT_W-1:0]   rolling_count;
        logic [PAYLOAD_W-1:0] raw_key;
    } kfcd_result_t;

    // byte i of the payload, byte 0 in the top bits
    function automatic logic [7:0] pay_byte(input logic [PAYLOAD_W-1:0] p, input int i);
        pay_byte = p[(PAYLOAD_W-1-8*i) -: 8];
    endfunction

endpackage

>>> rtl/kfcd_counter.sv
// ----------------------------------------------------------------------------
// kfcd_counter
// recovers the 16-bit rolling counter from the scrambled payload bytes
// ----------------------------------------------------------------------------
module kfcd_counter (
    input  logic [kfcd_pkg::PAYLOAD_W-1:0] payload,
    output logic [kfcd_pkg::COUNT_W-1:0]   rolling_count
);
    import kfcd_pkg::*;

    logic [7:0]  k1, k2, k3, k4, k5, k6, k7;
    logic [7:0]  lo, hi, sh1, sh2, t1, t2;
    logic [23:0] word, rotated;
    logic [47:0] word_dbl;
    logic [8:0]  rot_sum;
    logic [15:0] rot_prod;
    logic [3:0]  rot_quo;
    logic [8:0]  rot_rem;
    logic [4:0]  rot;

    always_comb
    begin
        k1 = pay_byte(payload, 1);
        k2 = pay_byte(payload, 2);
        k3 = pay_byte(payload, 3);
        k4 = pay_byte(payload, 4);
        k5 = pay_byte(payload, 5);
        k6 = pay_byte(payload, 6);
        k7 = pay_byte(payload, 7);

        // low byte: inverted picks
        lo = {~k5[7], ~k5[6], ~k6[1], ~k6[0], ~k5[1], ~k5[0], ~k4[7], ~k4[6]};

        sh1 = {k7[3:0], k5[3], k5[2], k6[7], k6[6]};
        sh2 = {k6[5:2], k7[7:4]};

        // (4 + lo) mod 24 via reciprocal multiply, exact for sums up to 259
        rot_sum  = {1'b0, lo} + ROT_OFFSET;
        rot_prod = {7'd0, rot_sum} * {8'd0, ROT_RECIP};
        rot_quo  = rot_prod[ROT_RECIP_SH +: 4];
        rot_rem  = rot_sum - ({5'd0, rot_quo} * {4'd0, ROT_MODULUS});
        rot      = rot_rem[4:0];

        word     = {k3, k1, k2};
        word_dbl = {word, word} << rot;
        rotated  = word_dbl[47:24];

        t1 = rotated[15:8] ^ sh1;
        t2 = rotated[7:0] ^ sh2;

        hi = {~t1[1], ~t1[0], ~t2[3], ~t2[2], ~t1[5], ~t1[4], ~t2[7], ~t2[6]};

        rolling_count = {hi, lo};
    end

endmodule

>>> rtl/keyfob_frame_counter_decode.sv
// ----------------------------------------------------------------------------
// keyfob_frame_counter_decode
// checks a received key-fob frame and decodes serial, button and counter
// ----------------------------------------------------------------------------
// path: an accepted frame is held in the input reg, decoded, then held in the
//   result reg, where the result becomes valid
// throughput: one frame per cycle; the result register drains while the next
//   frame sits in the input register, so a stalled sink only stops the input
//   once both stages hold an item
// reset: rst_n asynchronous active low clears both valid flags; data regs are
//   not reset
// ----------------------------------------------------------------------------
module keyfob_frame_counter_decode (
    input  logic                            clk,
    input  logic                            rst_n,
    // input frame
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata from bit 0: preamble_bytes[47:0], row_length[10:0],
    // payload[63:0], zero pad
    input  logic [kfcd_pkg::IN_DATA_W-1:0]  s_tdata,
    // decode result
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata from bit 0: serial_number[23:0], button[3:0],
    // rolling_count[15:0], raw_key[63:0], zero pad
    output logic [kfcd_pkg::OUT_DATA_W-1:0] m_tdata,
    // m_tuser: status[1:0]
    output logic [kfcd_pkg::STATUS_W-1:0]   m_tuser
);
    import kfcd_pkg::*;

    // input stage
    logic          in_valid_reg;
    kfcd_frame_t   in_frame_reg;
    kfcd_frame_t   in_frame_next;

    // result stage
    logic          out_valid_reg;
    kfcd_result_t  out_result_reg;
    kfcd_result_t  out_result_next;

    logic          out_load;
    logic          in_load;
    logic          has_sync;
    logic          len_ok;
    logic [COUNT_W-1:0] count_dec;

    // result stage takes an item when empty or when its item leaves now
    assign out_load = !out_valid_reg || m_tready;
    // input stage refills when empty or when its item moves to the result stage
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    // unpack input item, preamble in the lowest bits
    assign in_frame_next = {s_tdata[PREAMBLE_W-1:0],
                            s_tdata[PREAMBLE_W +: LENGTH_W],
                            s_tdata[PREAMBLE_W+LENGTH_W +: PAYLOAD_W]};

    kfcd_counter u_counter (
        .payload       (in_frame_reg.payload),
        .rolling_count (count_dec)
    );

    always_comb
    begin
        has_sync = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            if (in_frame_reg.preamble_bytes[8*i +: 8] == SYNC_BYTE)
            begin
                has_sync = 1'b1;
            end
        end
        // 65-bit rows are allowed, only the first 64 bits are used
        len_ok = (in_frame_reg.row_length == ROW_LEN_MIN) ||
                 (in_frame_reg.row_length == ROW_LEN_MAX);

        out_result_next = '0;
        if (!has_sync)
        begin
            out_result_next.status = STATUS_PREAMBLE_ERR;
        end
        else if (!len_ok)
        begin
            out_result_next.status = STATUS_LENGTH_ERR;
        end
        else
        begin
            out_result_next.status        = STATUS_OK;
            out_result_next.serial_number = {pay_byte(in_frame_reg.payload, 1),
                                             pay_byte(in_frame_reg.payload, 2),
                                             pay_byte(in_frame_reg.payload, 3)};
            // low nibble of payload byte 0
            out_result_next.button        = in_frame_reg.payload[PAYLOAD_W-5 -: BUTTON_W];
            out_result_next.rolling_count = count_dec;
            out_result_next.raw_key       = in_frame_reg.payload;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_frame_reg <= in_frame_next;
        end
        if (out_load && in_valid_reg)
        begin
            out_result_reg <= out_result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.status;
    assign m_tdata  = {{(OUT_DATA_W-SERIAL_W-BUTTON_W-COUNT_W-PAYLOAD_W){1'b0}},
                       out_result_reg.raw_key,
                       out_result_reg.rolling_count,
                       out_result_reg.button,
                       out_result_reg.serial_number};

endmodule

>>> tb/tb_keyfob_frame_counter_decode.sv
// ----------------------------------------------------------------------------
// tb_keyfob_frame_counter_decode
// self-checking stream testbench for the key-fob frame counter decoder
// ----------------------------------------------------------------------------
// every accepted frame is run through an in-bench decoder model and the
// expected result is queued; each result taken from the master side is
// compared field by field against the oldest queued entry. stimulus is a
// directed set (sync byte positions, length limits, rotation wrap points,
// payload extremes) followed by random frames under several idle/stall mixes,
// a long sink hold-off and drained bursts
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_keyfob_frame_counter_decode;

    import kfcd_pkg::*;

    // cycles with no transfer on either side before the run is declared hung
    localparam int HANG_LIMIT = 3000;
    // long sink hold-off, long enough to fill both pipeline stages
    localparam int SINK_HOLD  = 300;
    // result field offsets inside m_tdata
    localparam int SER_LSB = 0;
    localparam int BTN_LSB = SER_LSB + SERIAL_W;
    localparam int CNT_LSB = BTN_LSB + BUTTON_W;
    localparam int KEY_LSB = CNT_LSB + COUNT_W;
    localparam int PAD_LSB = KEY_LSB + PAYLOAD_W;
    localparam int IN_PAD  = IN_DATA_W - PREAMBLE_W - LENGTH_W - PAYLOAD_W;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // expected results, oldest first
    kfcd_result_t pending_decodes[$];

    int src_idle_pct   = 0;  // chance per cycle that the source holds back
    int sink_stall_pct = 0;  // chance per cycle that the sink is not ready
    int sink_hold_req  = 0;  // hold-off length handed to the sink process
    int sink_hold_left = 0;

    int error_count   = 0;
    int frames_sent   = 0;
    int results_seen  = 0;
    int n_decoded     = 0;
    int n_preamble_bad = 0;
    int n_length_bad  = 0;
    int idle_cycles   = 0;

    keyfob_frame_counter_decode u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // preamble_bytes, row_length, payload, pad
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // serial_number, button, rolling_count, raw_key, pad
        .m_tuser  (m_tuser)    // status
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------

    function automatic kfcd_result_t predict_decode(input kfcd_frame_t f);
        kfcd_result_t r;
        logic [7:0]   k [8];
        logic         sync_seen;
        logic [7:0]   lo, hi, sh1, sh2, t1, t2;
        logic [23:0]  word;
        logic [47:0]  twice;
        int           rot;
        r = '0;
        sync_seen = 1'b0;
        for (int i = 0; i < 6; i++)
            if (f.preamble_bytes[8*i +: 8] == SYNC_BYTE)
                sync_seen = 1'b1;
        // payload byte 0 sits in the top bits
        for (int i = 0; i < 8; i++)
            k[i] = f.payload[56-8*i +: 8];
        if (!sync_seen)
        begin
            r.status = STATUS_PREAMBLE_ERR;
            return r;
        end
        // preamble check wins over the length check
        if (f.row_length != ROW_LEN_MIN && f.row_length != ROW_LEN_MAX)
        begin
            r.status = STATUS_LENGTH_ERR;
            return r;
        end
        // low counter byte: inverted picks of bytes 4..6
        lo  = {~k[5][7], ~k[5][6], ~k[6][1], ~k[6][0],
               ~k[5][1], ~k[5][0], ~k[4][7], ~k[4][6]};
        sh1 = {k[7][3:0], k[5][3], k[5][2], k[6][7], k[6][6]};
        sh2 = {k[6][5:2], k[7][7:4]};
        // serial word rotated left; sum is formed wide, then reduced
        word  = {k[3], k[1], k[2]};
        rot   = (int'(ROT_OFFSET) + int'(lo)) % int'(ROT_MODULUS);
        twice = {word, word} << rot;
        t1    = twice[39:32] ^ sh1;
        t2    = twice[31:24] ^ sh2;
        hi  = {~t1[1], ~t1[0], ~t2[3], ~t2[2], ~t1[5], ~t1[4], ~t2[7], ~t2[6]};
        r.status        = STATUS_OK;
        r.serial_number = {k[1], k[2], k[3]};
        r.button        = k[0][3:0];
        r.rolling_count = {hi, lo};
        r.raw_key       = f.payload;
        return r;
    endfunction

    // plant a chosen low counter byte into a payload (used to hit rotation
    // wrap points on purpose)
    function automatic logic [63:0] with_low_count(input logic [63:0] p,
                                                   input logic [7:0]  lo);
        logic [63:0] q;
        q = p;
        q[30] = ~lo[0];
        q[31] = ~lo[1];
        q[16] = ~lo[2];
        q[17] = ~lo[3];
        q[8]  = ~lo[4];
        q[9]  = ~lo[5];
        q[22] = ~lo[6];
        q[23] = ~lo[7];
        return q;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly well-formed frames, some with a bad length, some raw noise
    function automatic kfcd_frame_t random_frame();
        kfcd_frame_t f;
        int          kind;
        logic [63:0] noise;
        kind  = $urandom_range(0, 99);
        noise = rand64();
        f.preamble_bytes = noise[PREAMBLE_W-1:0];
        f.payload        = rand64();
        if (kind < 85)
        begin
            f.preamble_bytes[8*$urandom_range(0, 5) +: 8] = SYNC_BYTE;
            if ($urandom_range(0, 3) == 0)
                f.preamble_bytes[8*$urandom_range(0, 5) +: 8] = SYNC_BYTE;
        end
        if (kind < 70)
            f.row_length = $urandom_range(0, 1) ? ROW_LEN_MAX : ROW_LEN_MIN;
        else if (kind < 85 || $urandom_range(0, 1))
            f.row_length = LENGTH_W'($urandom_range(0, 2047));
        else
            f.row_length = ROW_LEN_MIN;
        return f;
    endfunction

    // ------------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------------

    // offer one frame, with a random lead-in gap, and queue its expected result
    // once the block takes it; called at a rising edge, returns at the edge
    // of acceptance
    task automatic send_frame(input logic [PREAMBLE_W-1:0] pre,
                              input logic [LENGTH_W-1:0]   len,
                              input logic [PAYLOAD_W-1:0]  pay);
        kfcd_frame_t f;
        f.preamble_bytes = pre;
        f.row_length     = len;
        f.payload        = pay;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{IN_PAD{1'b0}}, f.payload, f.row_length, f.preamble_bytes};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_decodes.push_back(predict_decode(f));
        frames_sent++;
    endtask

    task automatic send_random(input int count);
        kfcd_frame_t f;
        repeat (count)
        begin
            f = random_frame();
            send_frame(f.preamble_bytes, f.row_length, f.payload);
        end
    endtask

    // drop valid and hold until every queued result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // sink side: random stalls plus an optional long hold-off
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (sink_hold_req > 0)
        begin
            sink_hold_left = sink_hold_req;
            sink_hold_req  = 0;
        end
        if (sink_hold_left > 0)
        begin
            m_tready <= 1'b0;
            sink_hold_left--;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name,
                                        input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        kfcd_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_decodes.size() == 0)
            begin
                $error("unexpected result item: status %0d, data 0x%0h",
                       m_tuser, m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_decodes.pop_front();
                check_field("status", 64'(want.status), 64'(m_tuser));
                check_field("serial_number", 64'(want.serial_number),
                            64'(m_tdata[SER_LSB +: SERIAL_W]));
                check_field("button", 64'(want.button),
                            64'(m_tdata[BTN_LSB +: BUTTON_W]));
                check_field("rolling_count", 64'(want.rolling_count),
                            64'(m_tdata[CNT_LSB +: COUNT_W]));
                check_field("raw_key", want.raw_key, m_tdata[KEY_LSB +: PAYLOAD_W]);
                check_field("tdata pad", 64'd0,
                            64'(m_tdata[OUT_DATA_W-1:PAD_LSB]));
                results_seen++;
                case (want.status)
                    STATUS_OK:           n_decoded++;
                    STATUS_PREAMBLE_ERR: n_preamble_bad++;
                    default:             n_length_bad++;
                endcase
            end
        end
    end

    // hang detector: counts cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles, %0d results pending",
                         idle_cycles, pending_decodes.size());
                $display("[keyfob_frame_counter_decode] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // hand-picked frames: sync byte placement, length limits, rotation wraps
    task automatic test_directed_frames();
        logic [PREAMBLE_W-1:0] all_fe;
        all_fe = {6{8'hFE}};
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // no sync byte at all, with a good and with a bad length
        send_frame('0, ROW_LEN_MIN, rand64());
        send_frame('0, '0, rand64());
        send_frame(all_fe, ROW_LEN_MIN, rand64());
        // all sync bytes, payload extremes
        send_frame('1, ROW_LEN_MIN, '0);
        send_frame('1, ROW_LEN_MAX, '1);
        // a single sync byte in each position, neighbors one below
        for (int i = 0; i < 6; i++)
        begin
            all_fe[8*i +: 8] = SYNC_BYTE;
            send_frame(all_fe, ROW_LEN_MIN, rand64());
            all_fe[8*i +: 8] = 8'hFE;
        end
        // lengths around and far from the accepted pair
        send_frame('1, ROW_LEN_MIN - 11'd1, rand64());
        send_frame('1, ROW_LEN_MAX + 11'd1, rand64());
        send_frame('1, 11'd0, rand64());
        send_frame('1, 11'd1024, rand64());
        send_frame('1, '1, rand64());
        // rotation of zero, of 23, and the widest sum before the modulo
        send_frame('1, ROW_LEN_MIN, with_low_count(rand64(), 8'd20));
        send_frame('1, ROW_LEN_MAX, with_low_count(rand64(), 8'd236));
        send_frame('1, ROW_LEN_MIN, with_low_count(rand64(), 8'd19));
        send_frame('1, ROW_LEN_MIN, with_low_count(rand64(), 8'd255));
        // button nibble against the ignored upper nibble of byte 0
        send_frame('1, ROW_LEN_MIN, 64'h0F00_0000_0000_0000);
        send_frame('1, ROW_LEN_MIN, 64'hF000_0000_0000_0000);
        send_frame('1, ROW_LEN_MAX, {16{4'hA}});
        send_frame('1, ROW_LEN_MIN, {16{4'h5}});
        wait_drained();
    endtask

    // random frames under one source idle / sink stall mix
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        send_random(count);
        wait_drained();
    endtask

    // sink holds off for a long stretch while the source keeps offering,
    // so both stages fill and s_tready drops
    task automatic test_sink_holdoff();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold_req  = SINK_HOLD;
        send_random(40);
        wait_drained();
    endtask

    // short bursts, each followed by a full drain before the next one
    task automatic test_drained_bursts();
        src_idle_pct   = 35;
        sink_stall_pct = 35;
        repeat (6)
        begin
            send_random(8);
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_random_traffic(0, 0, 300);
        test_random_traffic(74, 0, 300);
        test_random_traffic(0, 74, 300);
        test_random_traffic(35, 35, 300);
        test_sink_holdoff();
        test_drained_bursts();

        // let any stray result surface before the verdict
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (8) @(posedge clk);

        $display("sent %0d frames, checked %0d results:", frames_sent, results_seen);
        $display("  %0d decoded, %0d bad preamble, %0d bad length",
                 n_decoded, n_preamble_bad, n_length_bad);
        $display("phases: directed, free flow, source gaps, sink stalls, mixed,");
        $display("  long hold-off, drained bursts");
        if (error_count == 0 && pending_decodes.size() == 0)
            $display("[keyfob_frame_counter_decode] OK");
        else
            $display("[keyfob_frame_counter_decode] ERROR");
        $finish;
    end

endmodule
